// ----- rtl/equalizer_bar_pixel_generator_defines.svh -----
// assertion macros shared by the equalizer bar pixel generator rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef EQUALIZER_BAR_PIXEL_GENERATOR_DEFINES_SVH
`define EQUALIZER_BAR_PIXEL_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define EBPG_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define EBPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ebpg_pkg.sv -----
// shared constants, word types and helpers of the equalizer bar pixel generator
// no dependencies
`default_nettype none

package ebpg_pkg;

    localparam int unsigned NUM_BARS = 12;
    localparam int unsigned BAR_GAP  = 2;

    localparam logic [15:0] IDLE_COLOR = 16'h0019;
    localparam logic [15:0] DARK_BG    = 16'h0843;

    localparam logic [9:0] BEAT_MAX = 10'd1000;

    // frame folding: 2^16 mod 101 = 88
    localparam logic [6:0] FOLD_88    = 7'd88;
    localparam logic [6:0] MOD_BASE   = 7'd101;
    localparam logic [5:0] BAR_SPREAD = 6'd37;

    // reciprocals for division by constants, each followed by one correction step
    localparam logic [17:0] RECIP_101       = 18'd166111;
    localparam int unsigned RECIP_101_SHIFT = 24;
    localparam logic [20:0] RECIP_1K        = 21'd1073741;
    localparam int unsigned RECIP_1K_SHIFT  = 30;
    localparam logic [20:0] RECIP_1M        = 21'd1099511;
    localparam int unsigned RECIP_1M_SHIFT  = 40;

    localparam logic [9:0]  MULT_BASE  = 10'd500;
    localparam logic [9:0]  TEMP_BASE  = 10'd350;
    localparam logic [9:0]  TEMP_SPAN  = 10'd650;
    localparam logic [10:0] TINT_BASE  = 11'd850;
    localparam logic [4:0]  TINT_STEP  = 5'd25;
    localparam logic [9:0]  THOUSAND   = 10'd1000;
    localparam logic [19:0] MILLION    = 20'd1000000;
    localparam logic [7:0]  COMP_MAX   = 8'd255;

    // configuration register indexes
    typedef logic [1:0] ebpg_reg_idx_t;
    localparam ebpg_reg_idx_t REG_BASE_RED   = 2'd0;
    localparam ebpg_reg_idx_t REG_BASE_GREEN = 2'd1;
    localparam ebpg_reg_idx_t REG_BASE_BLUE  = 2'd2;

    localparam logic [7:0] RESET_RED   = 8'd180;
    localparam logic [7:0] RESET_GREEN = 8'd120;
    localparam logic [7:0] RESET_BLUE  = 8'd200;

    // word from bar location to height stage
    typedef struct packed {
        logic       idle;
        logic       draw;
        logic [9:0] beat;
        logic [3:0] bar;
        logic [6:0] vary;
        logic [7:0] y;
    } ebpg_loc_t;

    // word from height stage to shading stage
    typedef struct packed {
        logic       idle;
        logic       lit;
        logic [3:0] bar;
        logic [9:0] temp;
    } ebpg_hgt_t;

    function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        return {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ebpg_locate.sv -----
// bar location and frame variance pipeline, five stages
// depends on ebpg_pkg and the assertion macro header
`default_nettype none
`include "equalizer_bar_pixel_generator_defines.svh"

module ebpg_locate #(
    parameter int unsigned SCREEN_WIDTH  = 320,
    parameter int unsigned SCREEN_HEIGHT = 240
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              animate,
    input  wire logic [9:0]        beat_level,
    input  wire logic [30:0]       frame_count,
    input  wire logic [8:0]        column,
    input  wire logic [7:0]        row,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ebpg_pkg::ebpg_loc_t    out_word
);
    import ebpg_pkg::*;

    localparam int unsigned BAR_WIDTH = (SCREEN_WIDTH - (NUM_BARS + 1) * BAR_GAP) / NUM_BARS;
    localparam int unsigned STRIDE    = BAR_WIDTH + BAR_GAP;
    localparam int unsigned XW = ($clog2(SCREEN_WIDTH + 1) > 9) ? $clog2(SCREEN_WIDTH + 1) : 9;
    localparam int unsigned YW = ($clog2(SCREEN_HEIGHT + 1) > 8) ? $clog2(SCREEN_HEIGHT + 1) : 8;
    localparam int unsigned NST = 5;

    logic [NST-1:0] v_reg;
    logic [NST:0]   rdy;

    assign rdy[NST] = out_ready;
    genvar gi;
    generate
        for (gi = 0; gi < NST; gi++)
        begin : g_rdy
            assign rdy[gi] = !v_reg[gi] || rdy[gi+1];
        end
    endgenerate
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // stage 1: range checks, bar search, first frame fold
    logic [XW-1:0] x_ext;
    logic [XW-1:0] t_next;
    logic          inrange_next;
    logic [3:0]    bar_next;
    logic [9:0]    beat_next;
    logic [21:0]   f1_next;

    assign x_ext        = XW'(column);
    assign t_next       = x_ext - XW'(BAR_GAP);
    assign inrange_next = (x_ext >= XW'(BAR_GAP)) && (x_ext < XW'(SCREEN_WIDTH))
                          && (YW'(row) < YW'(SCREEN_HEIGHT));
    assign beat_next    = (beat_level > BEAT_MAX) ? BEAT_MAX : beat_level;
    assign f1_next      = 22'(frame_count[30:16]) * 22'(FOLD_88) + 22'(frame_count[15:0]);

    always_comb
    begin
        bar_next = '0;
        for (int k = 1; k <= NUM_BARS; k++)
        begin
            if (t_next >= XW'(k * STRIDE))
            begin
                bar_next = 4'(k);
            end
        end
    end

    logic          s1_idle_reg;
    logic          s1_inrange_reg;
    logic [9:0]    s1_beat_reg;
    logic [3:0]    s1_bar_reg;
    logic [XW-1:0] s1_t_reg;
    logic [21:0]   s1_f1_reg;
    logic [7:0]    s1_y_reg;

    // stage 2: pixel offset in bar, second frame fold
    logic [XW-1:0] px_next;
    logic          draw_next;
    logic [16:0]   f2_next;
    logic [8:0]    bar37_next;

    assign px_next    = s1_t_reg - XW'(s1_bar_reg * STRIDE);
    assign draw_next  = !s1_idle_reg && s1_inrange_reg && (s1_bar_reg < 4'(NUM_BARS))
                        && (px_next < XW'(BAR_WIDTH));
    assign f2_next    = 17'(s1_f1_reg[21:16]) * 17'(FOLD_88) + 17'(s1_f1_reg[15:0]);
    assign bar37_next = 9'(s1_bar_reg) * 9'(BAR_SPREAD);

    logic        s2_idle_reg;
    logic        s2_draw_reg;
    logic [9:0]  s2_beat_reg;
    logic [3:0]  s2_bar_reg;
    logic [7:0]  s2_y_reg;
    logic [16:0] s2_f2_reg;
    logic [8:0]  s2_bar37_reg;

    // stage 3: reciprocal quotient of the folded frame by 101
    logic [34:0] q101_prod;
    logic [10:0] q101_next;

    assign q101_prod = 35'(s2_f2_reg) * 35'(RECIP_101);
    assign q101_next = 11'(q101_prod >> RECIP_101_SHIFT);

    logic        s3_idle_reg;
    logic        s3_draw_reg;
    logic [9:0]  s3_beat_reg;
    logic [3:0]  s3_bar_reg;
    logic [7:0]  s3_y_reg;
    logic [16:0] s3_f2_reg;
    logic [8:0]  s3_bar37_reg;
    logic [10:0] s3_q_reg;

    // stage 4: remainder with one correction, add bar offset
    logic [16:0] rem_raw;
    logic [6:0]  fmod_next;
    logic [9:0]  sum_next;

    assign rem_raw   = s3_f2_reg - 17'(s3_q_reg) * 17'(MOD_BASE);
    assign fmod_next = (rem_raw >= 17'(MOD_BASE)) ? 7'(rem_raw - 17'(MOD_BASE)) : 7'(rem_raw);
    assign sum_next  = 10'(fmod_next) + 10'(s3_bar37_reg);

    logic        s4_idle_reg;
    logic        s4_draw_reg;
    logic [9:0]  s4_beat_reg;
    logic [3:0]  s4_bar_reg;
    logic [7:0]  s4_y_reg;
    logic [9:0]  s4_sum_reg;

    // stage 5: final reduction, sum stays below six times the modulus
    logic [9:0] vary_wide;
    logic [6:0] vary_next;

    always_comb
    begin
        if (s4_sum_reg >= 10'(5 * MOD_BASE))
        begin
            vary_wide = s4_sum_reg - 10'(5 * MOD_BASE);
        end
        else if (s4_sum_reg >= 10'(4 * MOD_BASE))
        begin
            vary_wide = s4_sum_reg - 10'(4 * MOD_BASE);
        end
        else if (s4_sum_reg >= 10'(3 * MOD_BASE))
        begin
            vary_wide = s4_sum_reg - 10'(3 * MOD_BASE);
        end
        else if (s4_sum_reg >= 10'(2 * MOD_BASE))
        begin
            vary_wide = s4_sum_reg - 10'(2 * MOD_BASE);
        end
        else if (s4_sum_reg >= 10'(MOD_BASE))
        begin
            vary_wide = s4_sum_reg - 10'(MOD_BASE);
        end
        else
        begin
            vary_wide = s4_sum_reg;
        end
    end
    assign vary_next = 7'(vary_wide);

    logic        s5_idle_reg;
    logic        s5_draw_reg;
    logic [9:0]  s5_beat_reg;
    logic [3:0]  s5_bar_reg;
    logic [7:0]  s5_y_reg;
    logic [6:0]  s5_vary_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s1_idle_reg    <= !animate;
            s1_inrange_reg <= inrange_next;
            s1_beat_reg    <= beat_next;
            s1_bar_reg     <= bar_next;
            s1_t_reg       <= t_next;
            s1_f1_reg      <= f1_next;
            s1_y_reg       <= row;
        end
        if (rdy[1])
        begin
            s2_idle_reg  <= s1_idle_reg;
            s2_draw_reg  <= draw_next;
            s2_beat_reg  <= s1_beat_reg;
            s2_bar_reg   <= s1_bar_reg;
            s2_y_reg     <= s1_y_reg;
            s2_f2_reg    <= f2_next;
            s2_bar37_reg <= bar37_next;
        end
        if (rdy[2])
        begin
            s3_idle_reg  <= s2_idle_reg;
            s3_draw_reg  <= s2_draw_reg;
            s3_beat_reg  <= s2_beat_reg;
            s3_bar_reg   <= s2_bar_reg;
            s3_y_reg     <= s2_y_reg;
            s3_f2_reg    <= s2_f2_reg;
            s3_bar37_reg <= s2_bar37_reg;
            s3_q_reg     <= q101_next;
        end
        if (rdy[3])
        begin
            s4_idle_reg <= s3_idle_reg;
            s4_draw_reg <= s3_draw_reg;
            s4_beat_reg <= s3_beat_reg;
            s4_bar_reg  <= s3_bar_reg;
            s4_y_reg    <= s3_y_reg;
            s4_sum_reg  <= sum_next;
        end
        if (rdy[4])
        begin
            s5_idle_reg <= s4_idle_reg;
            s5_draw_reg <= s4_draw_reg;
            s5_beat_reg <= s4_beat_reg;
            s5_bar_reg  <= s4_bar_reg;
            s5_y_reg    <= s4_y_reg;
            s5_vary_reg <= vary_next;
        end
    end

    assign out_word.idle = s5_idle_reg;
    assign out_word.draw = s5_draw_reg;
    assign out_word.beat = s5_beat_reg;
    assign out_word.bar  = s5_bar_reg;
    assign out_word.vary = s5_vary_reg;
    assign out_word.y    = s5_y_reg;

    `EBPG_ASSERT_IMPLY(a_vary_range, v_reg[NST-1] && s5_draw_reg,
        (s5_bar_reg < 4'(NUM_BARS)) && (s5_vary_reg < MOD_BASE),
        "drawn bar word has bar or variance out of range")
    `EBPG_ASSERT_IMPLY(a_draw_not_idle, v_reg[NST-1] && s5_idle_reg, !s5_draw_reg,
        "idle word marked as drawn")
    `EBPG_ASSERT_NEXT(a_stall_hold, v_reg[NST-1] && !out_ready,
        v_reg[NST-1] && $stable(s5_vary_reg) && $stable(s5_draw_reg),
        "stalled bar word changed")

endmodule

`default_nettype wire

// ----- rtl/ebpg_height.sv -----
// level, bar height, color temperature and lit test pipeline, seven stages
// depends on ebpg_pkg and the assertion macro header
`default_nettype none
`include "equalizer_bar_pixel_generator_defines.svh"

module ebpg_height #(
    parameter int unsigned SCREEN_HEIGHT = 240
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire ebpg_pkg::ebpg_loc_t  in_word,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output ebpg_pkg::ebpg_hgt_t       out_word
);
    import ebpg_pkg::*;

    localparam int unsigned HW  = $clog2(SCREEN_HEIGHT + 1);
    localparam int unsigned YW  = (HW > 8) ? HW : 8;
    localparam int unsigned PHW = 10 + HW;
    localparam int unsigned NST = 7;

    logic [NST-1:0] v_reg;
    logic [NST:0]   rdy;

    assign rdy[NST] = out_ready;
    genvar gi;
    generate
        for (gi = 0; gi < NST; gi++)
        begin : g_rdy
            assign rdy[gi] = !v_reg[gi] || rdy[gi+1];
        end
    endgenerate
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // stage 1: multiplier from variance (150/100 is 3/2), times beat
    logic [9:0]  mult_next;
    logic [19:0] bp_next;

    assign mult_next = MULT_BASE + 10'((11'(in_word.vary) * 11'd3) >> 1);
    assign bp_next   = 20'(in_word.beat) * 20'(mult_next);

    logic        s1_idle_reg;
    logic        s1_draw_reg;
    logic [3:0]  s1_bar_reg;
    logic [7:0]  s1_y_reg;
    logic [19:0] s1_p_reg;

    // stage 2: reciprocal quotient by 1000
    logic [40:0] lq_prod;
    logic [10:0] lq_next;

    assign lq_prod = 41'(s1_p_reg) * 41'(RECIP_1K);
    assign lq_next = 11'(lq_prod >> RECIP_1K_SHIFT);

    logic        s2_idle_reg;
    logic        s2_draw_reg;
    logic [3:0]  s2_bar_reg;
    logic [7:0]  s2_y_reg;
    logic [19:0] s2_p_reg;
    logic [10:0] s2_q_reg;

    // stage 3: correct the level quotient
    logic [19:0] lrem;
    logic [9:0]  level_next;

    assign lrem       = s2_p_reg - 20'(s2_q_reg) * 20'(THOUSAND);
    assign level_next = 10'(s2_q_reg) + ((lrem >= 20'(THOUSAND)) ? 10'd1 : 10'd0);

    logic        s3_idle_reg;
    logic        s3_draw_reg;
    logic [3:0]  s3_bar_reg;
    logic [7:0]  s3_y_reg;
    logic [9:0]  s3_level_reg;

    // stage 4: products for height and temperature
    logic [PHW-1:0] ph_next;
    logic [19:0]    pt_next;

    assign ph_next = PHW'(s3_level_reg) * PHW'(SCREEN_HEIGHT);
    assign pt_next = 20'(s3_level_reg) * 20'(TEMP_SPAN);

    logic           s4_idle_reg;
    logic           s4_draw_reg;
    logic [3:0]     s4_bar_reg;
    logic [7:0]     s4_y_reg;
    logic [PHW-1:0] s4_ph_reg;
    logic [19:0]    s4_pt_reg;

    // stage 5: reciprocal quotients by 1000
    logic [PHW+20:0] hq_prod;
    logic [40:0]     tq_prod;
    logic [10:0]     hq_next;
    logic [10:0]     tq_next;

    assign hq_prod = (PHW+21)'(s4_ph_reg) * (PHW+21)'(RECIP_1K);
    assign tq_prod = 41'(s4_pt_reg) * 41'(RECIP_1K);
    assign hq_next = 11'(hq_prod >> RECIP_1K_SHIFT);
    assign tq_next = 11'(tq_prod >> RECIP_1K_SHIFT);

    logic           s5_idle_reg;
    logic           s5_draw_reg;
    logic [3:0]     s5_bar_reg;
    logic [7:0]     s5_y_reg;
    logic [PHW-1:0] s5_ph_reg;
    logic [19:0]    s5_pt_reg;
    logic [10:0]    s5_hq_reg;
    logic [10:0]    s5_tq_reg;

    // stage 6: correct both quotients
    logic [PHW-1:0] hrem;
    logic [19:0]    trem;
    logic [HW-1:0]  h_next;
    logic [9:0]     temp_next;

    assign hrem      = s5_ph_reg - PHW'(s5_hq_reg) * PHW'(THOUSAND);
    assign trem      = s5_pt_reg - 20'(s5_tq_reg) * 20'(THOUSAND);
    assign h_next    = HW'(s5_hq_reg) + ((hrem >= PHW'(THOUSAND)) ? HW'(1) : HW'(0));
    assign temp_next = TEMP_BASE + 10'(s5_tq_reg)
                       + ((trem >= 20'(THOUSAND)) ? 10'd1 : 10'd0);

    logic          s6_idle_reg;
    logic          s6_draw_reg;
    logic [3:0]    s6_bar_reg;
    logic [7:0]    s6_y_reg;
    logic [HW-1:0] s6_h_reg;
    logic [9:0]    s6_temp_reg;

    // stage 7: lit when the row is at or below the bar top
    logic lit_next;

    assign lit_next = s6_draw_reg
                      && (YW'(s6_y_reg) >= (YW'(SCREEN_HEIGHT) - YW'(s6_h_reg)));

    logic       s7_idle_reg;
    logic       s7_lit_reg;
    logic [3:0] s7_bar_reg;
    logic [9:0] s7_temp_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s1_idle_reg <= in_word.idle;
            s1_draw_reg <= in_word.draw;
            s1_bar_reg  <= in_word.bar;
            s1_y_reg    <= in_word.y;
            s1_p_reg    <= bp_next;
        end
        if (rdy[1])
        begin
            s2_idle_reg <= s1_idle_reg;
            s2_draw_reg <= s1_draw_reg;
            s2_bar_reg  <= s1_bar_reg;
            s2_y_reg    <= s1_y_reg;
            s2_p_reg    <= s1_p_reg;
            s2_q_reg    <= lq_next;
        end
        if (rdy[2])
        begin
            s3_idle_reg  <= s2_idle_reg;
            s3_draw_reg  <= s2_draw_reg;
            s3_bar_reg   <= s2_bar_reg;
            s3_y_reg     <= s2_y_reg;
            s3_level_reg <= level_next;
        end
        if (rdy[3])
        begin
            s4_idle_reg <= s3_idle_reg;
            s4_draw_reg <= s3_draw_reg;
            s4_bar_reg  <= s3_bar_reg;
            s4_y_reg    <= s3_y_reg;
            s4_ph_reg   <= ph_next;
            s4_pt_reg   <= pt_next;
        end
        if (rdy[4])
        begin
            s5_idle_reg <= s4_idle_reg;
            s5_draw_reg <= s4_draw_reg;
            s5_bar_reg  <= s4_bar_reg;
            s5_y_reg    <= s4_y_reg;
            s5_ph_reg   <= s4_ph_reg;
            s5_pt_reg   <= s4_pt_reg;
            s5_hq_reg   <= hq_next;
            s5_tq_reg   <= tq_next;
        end
        if (rdy[5])
        begin
            s6_idle_reg <= s5_idle_reg;
            s6_draw_reg <= s5_draw_reg;
            s6_bar_reg  <= s5_bar_reg;
            s6_y_reg    <= s5_y_reg;
            s6_h_reg    <= h_next;
            s6_temp_reg <= temp_next;
        end
        if (rdy[6])
        begin
            s7_idle_reg <= s6_idle_reg;
            s7_lit_reg  <= lit_next;
            s7_bar_reg  <= s6_bar_reg;
            s7_temp_reg <= s6_temp_reg;
        end
    end

    assign out_word.idle = s7_idle_reg;
    assign out_word.lit  = s7_lit_reg;
    assign out_word.bar  = s7_bar_reg;
    assign out_word.temp = s7_temp_reg;

    `EBPG_ASSERT_IMPLY(a_level_bound, v_reg[2], s3_level_reg <= 10'd650,
        "level above the largest multiplier")
    `EBPG_ASSERT_IMPLY(a_lit_temp, v_reg[NST-1] && s7_lit_reg,
        !s7_idle_reg && (s7_temp_reg >= TEMP_BASE) && (s7_temp_reg <= 10'd772),
        "lit word is idle or has temperature out of range")

endmodule

`default_nettype wire

// ----- rtl/ebpg_shade.sv -----
// per-component scaling, saturation and rgb565 packing, four stages
// depends on ebpg_pkg and the assertion macro header
`default_nettype none
`include "equalizer_bar_pixel_generator_defines.svh"

module ebpg_shade (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire ebpg_pkg::ebpg_hgt_t  in_word,
    input  wire logic [7:0]           base_red,
    input  wire logic [7:0]           base_green,
    input  wire logic [7:0]           base_blue,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [15:0]               pixel_color
);
    import ebpg_pkg::*;

    localparam int unsigned NST = 4;

    logic [NST-1:0] v_reg;
    logic [NST:0]   rdy;

    assign rdy[NST] = out_ready;
    genvar gi;
    generate
        for (gi = 0; gi < NST; gi++)
        begin : g_rdy
            assign rdy[gi] = !v_reg[gi] || rdy[gi+1];
        end
    endgenerate
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (rdy[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // stage 1: tint (300*bar/12 is 25*bar) times temperature
    logic [10:0] tint_next;
    logic [20:0] tt_next;

    assign tint_next = TINT_BASE + 11'(in_word.bar) * 11'(TINT_STEP);
    assign tt_next   = 21'(in_word.temp) * 21'(tint_next);

    logic        s1_idle_reg;
    logic        s1_lit_reg;
    logic [20:0] s1_tt_reg;

    // stage 2: base component times scale, order red green blue
    logic [7:0]  base_c [3];
    logic [28:0] cp_next [3];

    assign base_c[0] = base_red;
    assign base_c[1] = base_green;
    assign base_c[2] = base_blue;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            cp_next[c] = 29'(base_c[c]) * 29'(s1_tt_reg);
        end
    end

    logic        s2_idle_reg;
    logic        s2_lit_reg;
    logic [28:0] s2_p_reg [3];

    // stage 3: reciprocal quotient by one million
    logic [49:0] cq_prod [3];
    logic [9:0]  cq_next [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            cq_prod[c] = 50'(s2_p_reg[c]) * 50'(RECIP_1M);
            cq_next[c] = 10'(cq_prod[c] >> RECIP_1M_SHIFT);
        end
    end

    logic        s3_idle_reg;
    logic        s3_lit_reg;
    logic [28:0] s3_p_reg [3];
    logic [9:0]  s3_q_reg [3];

    // stage 4: correct, saturate, pack and pick the pixel
    logic [29:0] crem [3];
    logic [9:0]  cfix [3];
    logic [7:0]  comp [3];
    logic [15:0] color_next;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            crem[c] = 30'(s3_p_reg[c]) - 30'(s3_q_reg[c]) * 30'(MILLION);
            cfix[c] = s3_q_reg[c] + ((crem[c] >= 30'(MILLION)) ? 10'd1 : 10'd0);
            comp[c] = (cfix[c] > 10'(COMP_MAX)) ? COMP_MAX : 8'(cfix[c]);
        end
        if (s3_idle_reg)
        begin
            color_next = IDLE_COLOR;
        end
        else if (s3_lit_reg)
        begin
            color_next = pack565(comp[0], comp[1], comp[2]);
        end
        else
        begin
            color_next = DARK_BG;
        end
    end

    logic [15:0] s4_color_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s1_idle_reg <= in_word.idle;
            s1_lit_reg  <= in_word.lit;
            s1_tt_reg   <= tt_next;
        end
        if (rdy[1])
        begin
            s2_idle_reg <= s1_idle_reg;
            s2_lit_reg  <= s1_lit_reg;
            for (int c = 0; c < 3; c++)
            begin
                s2_p_reg[c] <= cp_next[c];
            end
        end
        if (rdy[2])
        begin
            s3_idle_reg <= s2_idle_reg;
            s3_lit_reg  <= s2_lit_reg;
            for (int c = 0; c < 3; c++)
            begin
                s3_p_reg[c] <= s2_p_reg[c];
                s3_q_reg[c] <= cq_next[c];
            end
        end
        if (rdy[3])
        begin
            s4_color_reg <= color_next;
        end
    end

    assign pixel_color = s4_color_reg;

    `EBPG_ASSERT_IMPLY(a_comp_no_sat, v_reg[2] && s3_lit_reg,
        (s3_q_reg[0] <= 10'(COMP_MAX)) && (s3_q_reg[1] <= 10'(COMP_MAX))
        && (s3_q_reg[2] <= 10'(COMP_MAX)),
        "scaled component quotient above the component maximum")

endmodule

`default_nettype wire

// ----- rtl/equalizer_bar_pixel_generator.sv -----
// top level of the equalizer bar pixel generator: base color registers and pipeline
// depends on ebpg_pkg, ebpg_locate, ebpg_height, ebpg_shade
//
// usage:
//   input channel in_valid/in_ready carries one pixel word: animate, beat_level,
//   frame_count, column and row. output channel out_valid/out_ready returns one
//   rgb565 pixel_color per input word, in order.
//   throughput is one word per clock when not stalled; a word can enter on every
//   cycle and each stage holds one word, so up to sixteen words are in flight.
//   from acceptance to out_valid a word passes 5 stages of bar location and frame
//   variance, 7 of level, height and temperature, 4 of color scaling; the stage
//   count is set by the chain of constant divisions, each done as a reciprocal
//   multiply and one correction step.
//   base_red/green/blue are written via wr_en, wr_index, wr_data; the user must write
//   them only while the pipeline is empty (unenforced); an index past blue is ignored.
//   reset clears all stage valid bits and loads the base color 180, 120, 200.
//   when out_ready is low the last word holds, and earlier stages keep filling
//   until each is full; then in_ready drops. nothing is lost or repeated.
`default_nettype none

module equalizer_bar_pixel_generator #(
    parameter int unsigned SCREEN_WIDTH  = 320,
    parameter int unsigned SCREEN_HEIGHT = 240
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    animate,
    input  wire logic [9:0]              beat_level,
    input  wire logic [30:0]             frame_count,
    input  wire logic [8:0]              column,
    input  wire logic [7:0]              row,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [15:0]                  pixel_color,
    input  wire logic                    wr_en,
    input  wire ebpg_pkg::ebpg_reg_idx_t wr_index,
    input  wire logic [7:0]              wr_data
);
    import ebpg_pkg::*;

    logic [7:0] base_red_reg;
    logic [7:0] base_green_reg;
    logic [7:0] base_blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_red_reg   <= RESET_RED;
            base_green_reg <= RESET_GREEN;
            base_blue_reg  <= RESET_BLUE;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_BASE_RED:   base_red_reg   <= wr_data;
                REG_BASE_GREEN: base_green_reg <= wr_data;
                REG_BASE_BLUE:  base_blue_reg  <= wr_data;
                default:        ;
            endcase
        end
    end

    logic      loc_valid;
    logic      loc_ready;
    ebpg_loc_t loc_word;
    logic      hgt_valid;
    logic      hgt_ready;
    ebpg_hgt_t hgt_word;

    ebpg_locate #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_locate (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .animate     (animate),
        .beat_level  (beat_level),
        .frame_count (frame_count),
        .column      (column),
        .row         (row),
        .out_valid   (loc_valid),
        .out_ready   (loc_ready),
        .out_word    (loc_word)
    );

    ebpg_height #(
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_height (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (loc_valid),
        .in_ready  (loc_ready),
        .in_word   (loc_word),
        .out_valid (hgt_valid),
        .out_ready (hgt_ready),
        .out_word  (hgt_word)
    );

    ebpg_shade u_shade (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (hgt_valid),
        .in_ready    (hgt_ready),
        .in_word     (hgt_word),
        .base_red    (base_red_reg),
        .base_green  (base_green_reg),
        .base_blue   (base_blue_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_color (pixel_color)
    );

endmodule

`default_nettype wire
